[rtl/qhi_pkg.sv]
package qhi_pkg;

  localparam int unsigned VAL_W      = 48;
  localparam int unsigned FRAC_W     = 33;
  localparam int unsigned IDX_W      = 6;
  localparam int unsigned REG_W      = 47;
  localparam int unsigned CMDQ_DEPTH = 4;
  localparam int unsigned OUTQ_DEPTH = 16;

  typedef logic signed [VAL_W-1:0] q48_t;
  typedef logic signed [63:0]      q64_t;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_FORM   = 2'd1,
    CMD_INTERP = 2'd2
  } cmd_e;

  // Configuration register indexes.
  localparam logic REG_STEP_SIZE  = 1'b0;
  localparam logic REG_STEP_RECIP = 1'b1;

  localparam q64_t                ONE_Q   = 64'sh0000_0001_0000_0000;
  localparam logic [FRAC_W-1:0]   ONE_P   = 33'h1_0000_0000;
  localparam q64_t                MAX48_Q = 64'sd140737488355327;
  localparam q64_t                MIN48_Q = -64'sd140737488355328;

  // One queued word for the back end. Field a/b/c carry the payload of the
  // command: load uses all three, form uses a=half change and b=end slope,
  // interpolate uses b=end slope and p.
  typedef struct packed {
    cmd_e               kind;
    logic [IDX_W-1:0]   idx;
    q48_t               a;
    q48_t               b;
    q48_t               c;
    logic [FRAC_W-1:0]  p;
  } cmd_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    q48_t             value;
    q48_t             slope;
  } res_t;

  function automatic q64_t sx(input q48_t v);
    return 64'(v);
  endfunction

  function automatic q48_t sat48(input q64_t x);
    q48_t r;
    if (x > MAX48_Q) begin
      r = q48_t'(MAX48_Q);
    end else if (x < MIN48_Q) begin
      r = q48_t'(MIN48_Q);
    end else begin
      r = q48_t'(x);
    end
    return r;
  endfunction

endpackage

[rtl/quartic_hermite_interpolator_unit.sv]
// Each interpolate word gives one result; load and form words give none.
// Throughput: one word per cycle. An interpolate word is held behind a form
// word while the new quartic term is written back, and while the result
// queue has no room reserved for it.
// Reset clears the queues and sets both step registers to 1.0; the variable
// tables are not cleared and must be loaded before they are read.
module quartic_hermite_interpolator_unit import qhi_pkg::*; #(
  parameter int unsigned MAX_VARS = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  logic [1:0]        cmd_i,
  input  logic [IDX_W-1:0]  var_index_i,
  input  q48_t              start_value_i,
  input  q48_t              start_slope_i,
  input  q48_t              step_change_i,
  input  q48_t              half_change_i,
  input  q48_t              end_slope_i,
  input  logic [FRAC_W-1:0] frac_i,
  output logic              empty,
  input  logic              pop,
  output logic [IDX_W-1:0]  out_index_o,
  output q48_t              interp_value_o,
  output q48_t              interp_slope_o,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [REG_W-1:0]  cfg_wdata_i
);

  logic [REG_W-1:0] step_size_q, step_recip_q;
  cmd_t             head;
  logic             head_valid, head_take;
  logic             res_valid, res_pop;
  res_t             res, res_head;
  logic             outq_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_size_q  <= REG_W'(64'h1_0000_0000);
      step_recip_q <= REG_W'(64'h1_0000_0000);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_STEP_SIZE:  step_size_q  <= cfg_wdata_i;
        REG_STEP_RECIP: step_recip_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  qhi_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .full_o        (full),
    .cmd_i         (cmd_i),
    .var_index_i   (var_index_i),
    .start_value_i (start_value_i),
    .start_slope_i (start_slope_i),
    .step_change_i (step_change_i),
    .half_change_i (half_change_i),
    .end_slope_i   (end_slope_i),
    .frac_i        (frac_i),
    .head_o        (head),
    .head_valid_o  (head_valid),
    .head_take_i   (head_take)
  );

  qhi_back #(
    .MAX_VARS (MAX_VARS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_size_i  (step_size_q),
    .step_recip_i (step_recip_q),
    .cmd_i        (head),
    .cmd_valid_i  (head_valid),
    .cmd_take_o   (head_take),
    .res_pop_i    (res_pop),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  // Space in the result queue is reserved at issue, so a write never finds
  // it full.
  assign res_pop = pop && !empty;

  qhi_fifo #(
    .DEPTH (OUTQ_DEPTH),
    .T     (res_t)
  ) u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (res_valid && !outq_full),
    .wdata_i (res),
    .rd_i    (res_pop),
    .rdata_o (res_head),
    .full_o  (outq_full),
    .empty_o (empty)
  );

  assign out_index_o    = res_head.idx;
  assign interp_value_o = res_head.value;
  assign interp_slope_o = res_head.slope;

endmodule

[rtl/qhi_fifo.sv]
module qhi_fifo import qhi_pkg::*; #(
  parameter int unsigned DEPTH = 4,
  parameter type T = logic
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_i,
  input  T     wdata_i,
  input  logic rd_i,
  output T     rdata_o,
  output logic full_o,
  output logic empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  T                 mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (rd_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (wr_i && !rd_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (rd_i && !wr_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

[rtl/qhi_mul.sv]
module qhi_mul import qhi_pkg::*; (
  input  logic clk_i,
  input  q64_t a_i,
  input  q64_t b_i,
  output q64_t p_o
);

  localparam logic [60:0] LIM   = 61'd1 << 58;
  localparam logic [63:0] HI_LIM = 64'd1 << 26;

  logic [63:0] ua, ub;
  logic        neg;
  logic [63:0] hi_q, m1_q, m2_q, lo_q;
  logic        neg_q;
  logic        ovf;
  logic [32:0] rnd;
  logic [60:0] sum, mag;
  q64_t        res, prod_q;

  always_comb begin
    ua  = a_i[63] ? (64'd0 - a_i) : a_i;
    ub  = b_i[63] ? (64'd0 - b_i) : b_i;
    neg = a_i[63] ^ b_i[63];
  end

  // First stage: four 32x32 partial products of the magnitudes.
  always_ff @(posedge clk_i) begin
    hi_q  <= ua[63:32] * ub[63:32];
    m1_q  <= ua[31:0] * ub[63:32];
    m2_q  <= ua[63:32] * ub[31:0];
    lo_q  <= ua[31:0] * ub[31:0];
    neg_q <= neg;
  end

  // Second stage: round half away from zero, clamp the magnitude, restore sign.
  always_comb begin
    ovf = (hi_q >= HI_LIM) || (m1_q > 64'(LIM)) || (m2_q > 64'(LIM));
    rnd = 33'((65'(lo_q) + 65'h0_8000_0000) >> 32);
    sum = 61'({hi_q[25:0], 32'd0}) + 61'(m1_q) + 61'(m2_q) + 61'(rnd);
    mag = (ovf || (sum > LIM)) ? LIM : sum;
    res = neg_q ? (64'sd0 - q64_t'(mag)) : q64_t'(mag);
  end

  always_ff @(posedge clk_i) begin
    prod_q <= res;
  end

  assign p_o = prod_q;

endmodule

[rtl/qhi_front.sv]
module qhi_front import qhi_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  output logic              full_o,
  input  logic [1:0]        cmd_i,
  input  logic [IDX_W-1:0]  var_index_i,
  input  q48_t              start_value_i,
  input  q48_t              start_slope_i,
  input  q48_t              step_change_i,
  input  q48_t              half_change_i,
  input  q48_t              end_slope_i,
  input  logic [FRAC_W-1:0] frac_i,
  output cmd_t              head_o,
  output logic              head_valid_o,
  input  logic              head_take_i
);

  cmd_t ent;
  logic keep;
  logic empty;

  // Classify the incoming word; the unused command code is dropped here.
  always_comb begin
    ent.kind = cmd_e'(cmd_i);
    ent.idx  = var_index_i;
    ent.a    = '0;
    ent.b    = '0;
    ent.c    = '0;
    ent.p    = (frac_i > ONE_P) ? ONE_P : frac_i;
    keep     = 1'b1;
    unique case (cmd_e'(cmd_i))
      CMD_LOAD: begin
        ent.a = start_value_i;
        ent.b = start_slope_i;
        ent.c = step_change_i;
      end
      CMD_FORM: begin
        ent.a = half_change_i;
        ent.b = end_slope_i;
      end
      CMD_INTERP: begin
        ent.b = end_slope_i;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  qhi_fifo #(
    .DEPTH (CMDQ_DEPTH),
    .T     (cmd_t)
  ) u_cmdq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (push_i && !full_o && keep),
    .wdata_i (ent),
    .rd_i    (head_take_i),
    .rdata_o (head_o),
    .full_o  (full_o),
    .empty_o (empty)
  );

  assign head_valid_o = !empty;

endmodule

[rtl/qhi_back.sv]
module qhi_back import qhi_pkg::*; #(
  parameter int unsigned MAX_VARS = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [REG_W-1:0] step_size_i,
  input  logic [REG_W-1:0] step_recip_i,
  input  cmd_t             cmd_i,
  input  logic             cmd_valid_i,
  output logic             cmd_take_o,
  input  logic             res_pop_i,
  output logic             res_valid_o,
  output res_t             res_o
);

  localparam int unsigned AW     = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1;
  localparam int unsigned CRED_W = $clog2(OUTQ_DEPTH + 1);

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    q48_t             y0;
    q48_t             y0p;
    q48_t             dy;
    q48_t             c4;
    q48_t             y1p;
  } carry_t;

  q48_t mem_y0  [MAX_VARS];
  q48_t mem_y0p [MAX_VARS];
  q48_t mem_dy  [MAX_VARS];
  q48_t mem_c4  [MAX_VARS];

  logic              ok;
  logic [AW-1:0]     addr;
  logic              form_busy, can_issue;
  logic              issue_load, issue_form, issue_interp;
  logic [CRED_W-1:0] cred_q, cred_d;
  logic [3:1]        vf_q;
  logic [10:1]       vi_q;

  q48_t rd_y0_q, rd_y0p_q, rd_dy_q, rd_c4_q;
  logic [IDX_W-1:0]  s1_idx_q;
  logic              s1_ok_q;
  q48_t              s1_a_q, s1_b_q;
  logic [FRAC_W-1:0] s1_p_q;

  q64_t h64, hinv64;

  assign h64    = 64'(step_size_i);
  assign hinv64 = 64'(step_recip_i);

  // Issue control. An interpolate word waits while a quartic term is on its
  // way to memory, and while the result queue has no room reserved for it.
  assign form_busy = |vf_q;
  assign ok        = (32'(cmd_i.idx) < MAX_VARS);
  assign addr      = AW'(cmd_i.idx);

  always_comb begin
    can_issue = cmd_valid_i;
    if (cmd_i.kind == CMD_INTERP) begin
      can_issue = cmd_valid_i && !form_busy && (cred_q < CRED_W'(OUTQ_DEPTH));
    end
    issue_load   = can_issue && (cmd_i.kind == CMD_LOAD);
    issue_form   = can_issue && (cmd_i.kind == CMD_FORM);
    issue_interp = can_issue && (cmd_i.kind == CMD_INTERP);
  end

  assign cmd_take_o = can_issue;

  always_comb begin
    cred_d = cred_q;
    if (issue_interp && !res_pop_i) begin
      cred_d = cred_q + 1'b1;
    end else if (res_pop_i && !issue_interp) begin
      cred_d = cred_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cred_q <= '0;
      vf_q   <= '0;
      vi_q   <= '0;
    end else begin
      cred_q <= cred_d;
      vf_q   <= {vf_q[2:1], issue_form};
      vi_q   <= {vi_q[9:1], issue_interp};
    end
  end

  // Stored tables: loads write at issue, every issue reads the same row.
  always_ff @(posedge clk_i) begin
    if (issue_load && ok) begin
      mem_y0[addr]  <= cmd_i.a;
      mem_y0p[addr] <= cmd_i.b;
      mem_dy[addr]  <= cmd_i.c;
    end
    rd_y0_q  <= mem_y0[addr];
    rd_y0p_q <= mem_y0p[addr];
    rd_dy_q  <= mem_dy[addr];
  end

  always_ff @(posedge clk_i) begin
    s1_idx_q <= cmd_i.idx;
    s1_ok_q  <= ok;
    s1_a_q   <= cmd_i.a;
    s1_b_q   <= cmd_i.b;
    s1_p_q   <= cmd_i.p;
  end

  // Quartic term path.
  q64_t             form_prod, lin1;
  q64_t             lin_q [2:3];
  logic [IDX_W-1:0] fidx_q [2:3];
  logic             fok_q [2:3];
  q48_t             c4_new;

  assign lin1 = ((sx(s1_a_q) <<< 1) - sx(rd_dy_q)) <<< 3;

  qhi_mul u_form (
    .clk_i (clk_i),
    .a_i   (h64 <<< 1),
    .b_i   (sx(s1_b_q) - sx(rd_y0p_q)),
    .p_o   (form_prod)
  );

  always_ff @(posedge clk_i) begin
    lin_q[2]  <= lin1;
    lin_q[3]  <= lin_q[2];
    fidx_q[2] <= s1_idx_q;
    fidx_q[3] <= fidx_q[2];
    fok_q[2]  <= s1_ok_q;
    fok_q[3]  <= fok_q[2];
  end

  assign c4_new = sat48(lin_q[3] + form_prod);

  always_ff @(posedge clk_i) begin
    if (vf_q[3] && fok_q[3]) begin
      mem_c4[AW'(fidx_q[3])] <= c4_new;
    end
    rd_c4_q <= mem_c4[addr];
  end

  // Interpolation path: four levels of products, then a two-step sum.
  carry_t            c1;
  carry_t            cr_q [2:10];
  logic [FRAC_W-1:0] p_q [2:3];

  always_comb begin
    c1.idx = s1_idx_q;
    c1.y1p = s1_b_q;
    c1.y0  = s1_ok_q ? rd_y0_q  : '0;
    c1.y0p = s1_ok_q ? rd_y0p_q : '0;
    c1.dy  = s1_ok_q ? rd_dy_q  : '0;
    c1.c4  = s1_ok_q ? rd_c4_q  : '0;
  end

  always_ff @(posedge clk_i) begin
    cr_q[2] <= c1;
    for (int k = 3; k <= 10; k++) begin
      cr_q[k] <= cr_q[k-1];
    end
    p_q[2] <= s1_p_q;
    p_q[3] <= p_q[2];
  end

  q64_t p1, q1, p3, q3;
  q64_t pp, qq, pq, b2, b3;
  q64_t a1, qqp, ppq, a4, tb1, tb4;
  q64_t a2, a3m, b4m;
  q64_t b2_q [4:7];
  q64_t b3_q [4:7];
  q64_t a1_q [6:7];
  q64_t a4_q [6:7];
  q64_t b1_q [6:7];

  assign p1 = 64'(s1_p_q);
  assign q1 = ONE_Q - p1;
  assign p3 = 64'(p_q[3]);
  assign q3 = ONE_Q - p3;

  qhi_mul u_pp (.clk_i(clk_i), .a_i(p1), .b_i(p1), .p_o(pp));
  qhi_mul u_qq (.clk_i(clk_i), .a_i(q1), .b_i(q1), .p_o(qq));
  qhi_mul u_pq (.clk_i(clk_i), .a_i(p1), .b_i(q1), .p_o(pq));
  qhi_mul u_b2 (.clk_i(clk_i), .a_i(q1), .b_i(ONE_Q - ((p1 <<< 1) + p1)), .p_o(b2));
  qhi_mul u_b3 (.clk_i(clk_i), .a_i(p1), .b_i(ONE_Q - ((q1 <<< 1) + q1)), .p_o(b3));

  qhi_mul u_a1  (.clk_i(clk_i), .a_i(pp), .b_i(ONE_Q + (q3 <<< 1)), .p_o(a1));
  qhi_mul u_qqp (.clk_i(clk_i), .a_i(qq), .b_i(p3),      .p_o(qqp));
  qhi_mul u_ppq (.clk_i(clk_i), .a_i(pp), .b_i(q3),      .p_o(ppq));
  qhi_mul u_a4  (.clk_i(clk_i), .a_i(pp), .b_i(qq),      .p_o(a4));
  qhi_mul u_tb1 (.clk_i(clk_i), .a_i(pq), .b_i(hinv64),  .p_o(tb1));
  qhi_mul u_tb4 (.clk_i(clk_i), .a_i(pq), .b_i(q3 - p3), .p_o(tb4));

  always_ff @(posedge clk_i) begin
    b2_q[4] <= b2;
    b3_q[4] <= b3;
    for (int k = 5; k <= 7; k++) begin
      b2_q[k] <= b2_q[k-1];
      b3_q[k] <= b3_q[k-1];
    end
    a1_q[6] <= a1;
    a1_q[7] <= a1_q[6];
    a4_q[6] <= a4;
    a4_q[7] <= a4_q[6];
    b1_q[6] <= (tb1 <<< 2) + (tb1 <<< 1);
    b1_q[7] <= b1_q[6];
  end

  qhi_mul u_a2 (.clk_i(clk_i), .a_i(qqp), .b_i(h64),    .p_o(a2));
  qhi_mul u_a3 (.clk_i(clk_i), .a_i(ppq), .b_i(h64),    .p_o(a3m));
  qhi_mul u_b4 (.clk_i(clk_i), .a_i(tb4), .b_i(hinv64), .p_o(b4m));

  q64_t f1, f2, f3, f4, g1, g2, g3, g4;
  q64_t ya_q, yb_q, sa_q, sb_q;

  // The end-slope value coefficient is the negated product.
  qhi_mul u_f1 (.clk_i(clk_i), .a_i(a1_q[7]),       .b_i(sx(cr_q[7].dy)),  .p_o(f1));
  qhi_mul u_f2 (.clk_i(clk_i), .a_i(a2),            .b_i(sx(cr_q[7].y0p)), .p_o(f2));
  qhi_mul u_f3 (.clk_i(clk_i), .a_i(64'sd0 - a3m),  .b_i(sx(cr_q[7].y1p)), .p_o(f3));
  qhi_mul u_f4 (.clk_i(clk_i), .a_i(a4_q[7]),       .b_i(sx(cr_q[7].c4)),  .p_o(f4));
  qhi_mul u_g1 (.clk_i(clk_i), .a_i(b1_q[7]),       .b_i(sx(cr_q[7].dy)),  .p_o(g1));
  qhi_mul u_g2 (.clk_i(clk_i), .a_i(b2_q[7]),       .b_i(sx(cr_q[7].y0p)), .p_o(g2));
  qhi_mul u_g3 (.clk_i(clk_i), .a_i(b3_q[7]),       .b_i(sx(cr_q[7].y1p)), .p_o(g3));
  qhi_mul u_g4 (.clk_i(clk_i), .a_i(b4m <<< 1),     .b_i(sx(cr_q[7].c4)),  .p_o(g4));

  always_ff @(posedge clk_i) begin
    ya_q <= sx(cr_q[9].y0) + f1 + f2;
    yb_q <= f3 + f4;
    sa_q <= g1 + g2;
    sb_q <= g3 + g4;
  end

  assign res_valid_o = vi_q[10];
  assign res_o.idx   = cr_q[10].idx;
  assign res_o.value = sat48(ya_q + yb_q);
  assign res_o.slope = sat48(sa_q + sb_q);

endmodule

[rtl/qhi_checker.sv]
module qhi_checker import qhi_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             push,
  input logic             full,
  input logic             pop,
  input logic             empty,
  input logic [IDX_W-1:0] out_index_o
);

  // A waiting word is not lost, and its index does not change, before it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> !empty)
    else $error("result word dropped without a pop");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> $stable(out_index_o))
    else $error("waiting result word changed");

  // The queue only fills through an accepted word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(full) |-> $past(push && !full))
    else $error("input queue filled without a push");

  // The result side only drains through a pop.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(empty) |-> $past(pop))
    else $error("result queue drained without a pop");

endmodule

bind quartic_hermite_interpolator_unit qhi_checker u_chk (.*);

[tb/sv/tb_quartic_hermite_interpolator_unit.sv]
module tb_quartic_hermite_interpolator_unit;
  import qhi_pkg::*;

  localparam logic [1:0]   CMD_IGNORED    = 2'd3;
  localparam logic [63:0]  PROD_CLAMP     = 64'd1 << 58;
  localparam q48_t         Q48_MAX        = 48'sh7FFF_FFFF_FFFF;
  localparam q48_t         Q48_MIN        = 48'sh8000_0000_0000;
  localparam logic [46:0]  REG_MAX        = 47'h7FFF_FFFF_FFFF;
  localparam int           NUM_VARS       = 64;
  localparam int           SETTLE_CYCLES  = 30;

  typedef struct {
    logic [1:0]        cmd;
    logic [IDX_W-1:0]  idx;
    q48_t              y0;
    q48_t              y0_slope;
    q48_t              dy;
    q48_t              half;
    q48_t              y1_slope;
    logic [FRAC_W-1:0] frac;
    bit                typed;
    q48_t              exp_value;
    q48_t              exp_slope;
  } word_t;

  typedef struct {
    logic [IDX_W-1:0] idx;
    q48_t             value;
    q48_t             slope;
  } interp_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              push;
  logic              full;
  logic [1:0]        cmd_i;
  logic [IDX_W-1:0]  var_index_i;
  q48_t              start_value_i;
  q48_t              start_slope_i;
  q48_t              step_change_i;
  q48_t              half_change_i;
  q48_t              end_slope_i;
  logic [FRAC_W-1:0] frac_i;
  logic              empty;
  logic              pop;
  logic [IDX_W-1:0]  out_index_o;
  q48_t              interp_value_o;
  q48_t              interp_slope_o;
  logic              cfg_we_i;
  logic              cfg_idx_i;
  logic [REG_W-1:0]  cfg_wdata_i;

  // Shadow copy of the block's state.
  logic [REG_W-1:0] step_h;
  logic [REG_W-1:0] step_hinv;
  q48_t             y0_tab   [NUM_VARS];
  q48_t             slope_tab[NUM_VARS];
  q48_t             dy_tab   [NUM_VARS];
  q48_t             c4_tab   [NUM_VARS];
  bit               loaded   [NUM_VARS];
  bit               formed   [NUM_VARS];

  interp_t interp_expect_q[$];
  word_t   directed_rows[$];
  int      error_count = 0;
  bit      rx_gaps = 1'b1;
  bit      hold_req = 1'b0;
  int      hold_left = 0;
  int      stall_left = 0;

  quartic_hermite_interpolator_unit u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .push(push), .full(full),
    .cmd_i(cmd_i), .var_index_i(var_index_i),
    .start_value_i(start_value_i), .start_slope_i(start_slope_i),
    .step_change_i(step_change_i), .half_change_i(half_change_i),
    .end_slope_i(end_slope_i), .frac_i(frac_i),
    .empty(empty), .pop(pop),
    .out_index_o(out_index_o), .interp_value_o(interp_value_o),
    .interp_slope_o(interp_slope_o),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_wdata_i(cfg_wdata_i)
  );

  always #1 clk_i = ~clk_i;

  initial begin
    #2000000;
    $display("tb_quartic_hermite_interpolator_unit: done, errors");
    $finish;
  end

  // Q32 product, rounded half away from zero, magnitude clamped to 2^58.
  function automatic q64_t qmul(input q64_t a, input q64_t b);
    logic        neg;
    logic [63:0] ua, ub, a0, a1, b0, b1, hi, m1, m2, lo, r;
    neg = (a < 0) != (b < 0);
    ua  = (a < 0) ? -a : a;
    ub  = (b < 0) ? -b : b;
    a0  = {32'd0, ua[31:0]};
    a1  = ua >> 32;
    b0  = {32'd0, ub[31:0]};
    b1  = ub >> 32;
    hi  = a1 * b1;
    m1  = a0 * b1;
    m2  = a1 * b0;
    lo  = a0 * b0;
    if (hi >= (64'd1 << 26) || m1 > PROD_CLAMP || m2 > PROD_CLAMP) begin
      r = PROD_CLAMP;
    end else begin
      r = (hi << 32) + m1 + m2 + ((lo + 64'h8000_0000) >> 32);
      if (r > PROD_CLAMP) r = PROD_CLAMP;
    end
    return neg ? -$signed(r) : $signed(r);
  endfunction

  function automatic q48_t clamp48(input q64_t x);
    q64_t hi_lim, lo_lim;
    hi_lim = Q48_MAX;
    lo_lim = Q48_MIN;
    if (x > hi_lim) return Q48_MAX;
    if (x < lo_lim) return Q48_MIN;
    return x[47:0];
  endfunction

  // Updates the shadow tables for one accepted word and queues the expected
  // interpolation result, if the word gives one.
  function automatic void hermite_predict(input word_t w);
    q64_t    h, hinv, y1p, y0, y0p, dy, c4, p, q, pp, qq, pq;
    q64_t    a1, a2, a3, a4, b1, b2, b3, b4, yv, ys, half;
    interp_t e;
    h    = $signed({17'd0, step_h});
    hinv = $signed({17'd0, step_hinv});
    y1p  = w.y1_slope;
    case (w.cmd)
      CMD_LOAD: begin
        y0_tab[w.idx]    = w.y0;
        slope_tab[w.idx] = w.y0_slope;
        dy_tab[w.idx]    = w.dy;
        loaded[w.idx]    = 1'b1;
      end
      CMD_FORM: begin
        half = w.half;
        dy   = dy_tab[w.idx];
        y0p  = slope_tab[w.idx];
        c4   = 8 * (2 * half - dy) + qmul(2 * h, y1p - y0p);
        c4_tab[w.idx] = clamp48(c4);
        formed[w.idx] = 1'b1;
      end
      CMD_INTERP: begin
        y0  = y0_tab[w.idx];
        y0p = slope_tab[w.idx];
        dy  = dy_tab[w.idx];
        c4  = c4_tab[w.idx];
        p   = (w.frac > ONE_P) ? ONE_Q : $signed({31'd0, w.frac});
        q   = ONE_Q - p;
        pp  = qmul(p, p);
        qq  = qmul(q, q);
        pq  = qmul(p, q);
        a1  = qmul(pp, ONE_Q + 2 * q);
        a2  = qmul(qmul(qq, p), h);
        a3  = -qmul(qmul(pp, q), h);
        a4  = qmul(pp, qq);
        b1  = 6 * qmul(pq, hinv);
        b2  = qmul(q, ONE_Q - 3 * p);
        b3  = qmul(p, ONE_Q - 3 * q);
        b4  = 2 * qmul(qmul(pq, q - p), hinv);
        yv  = y0 + qmul(a1, dy) + qmul(a2, y0p) + qmul(a3, y1p) + qmul(a4, c4);
        ys  = qmul(b1, dy) + qmul(b2, y0p) + qmul(b3, y1p) + qmul(b4, c4);
        e.idx   = w.idx;
        e.value = w.typed ? w.exp_value : clamp48(yv);
        e.slope = w.typed ? w.exp_slope : clamp48(ys);
        interp_expect_q.push_back(e);
      end
      default: ;
    endcase
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic q48_t rand_q48();
    q48_t v;
    case ($urandom_range(0, 7))
      0: v = Q48_MAX;
      1: v = Q48_MIN;
      2: v = '0;
      3: v = $signed({12'd0, 4'($urandom_range(0, 15)), $urandom}) *
             (($urandom_range(0, 1) == 0) ? 1 : -1);
      default: v = 48'({$urandom, $urandom} >> 16);
    endcase
    return v;
  endfunction

  function automatic logic [FRAC_W-1:0] rand_frac();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return ONE_P;
      2: return {1'b1, 32'($urandom)};
      default: return {1'b0, 32'($urandom)};
    endcase
  endfunction

  // Well-formed sequences per variable: load, then form, then interpolate,
  // with some reloads, reforms and ignored words mixed in.
  function automatic word_t rand_word();
    word_t w;
    int    r;
    w.idx      = IDX_W'($urandom_range(0, NUM_VARS - 1));
    w.y0       = rand_q48();
    w.y0_slope = rand_q48();
    w.dy       = rand_q48();
    w.half     = rand_q48();
    w.y1_slope = rand_q48();
    w.frac     = rand_frac();
    w.typed    = 1'b0;
    w.exp_value = '0;
    w.exp_slope = '0;
    r = $urandom_range(0, 99);
    if (r < 4) begin
      w.cmd = CMD_IGNORED;
    end else if (!loaded[w.idx]) begin
      w.cmd = CMD_LOAD;
    end else if (!formed[w.idx]) begin
      w.cmd = (r < 70) ? CMD_FORM : CMD_LOAD;
    end else if (r < 15) begin
      w.cmd = CMD_LOAD;
    end else if (r < 30) begin
      w.cmd = CMD_FORM;
    end else begin
      w.cmd = CMD_INTERP;
    end
    return w;
  endfunction

  task automatic send_word(input word_t w, input bit gaps);
    int g;
    cmd_i         <= w.cmd;
    var_index_i   <= w.idx;
    start_value_i <= w.y0;
    start_slope_i <= w.y0_slope;
    step_change_i <= w.dy;
    half_change_i <= w.half;
    end_slope_i   <= w.y1_slope;
    frac_i        <= w.frac;
    push          <= 1'b1;
    do @(posedge clk_i); while (full);
    hermite_predict(w);
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      push <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  // Load and form words give no result, so after the last result the block
  // may still be busy; let its latency pass before touching a register.
  task automatic write_reg(input logic sel, input logic [REG_W-1:0] data);
    push <= 1'b0;
    while (interp_expect_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= sel;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    if (sel == REG_STEP_SIZE) step_h = data;
    else step_hinv = data;
    cfg_we_i <= 1'b0;
  endtask

  task automatic add_row(input logic [1:0] cmd, input logic [IDX_W-1:0] idx,
                         input q48_t y0, input q48_t y0s, input q48_t dy,
                         input q48_t half, input q48_t y1s,
                         input logic [FRAC_W-1:0] frac, input bit typed,
                         input q48_t ev, input q48_t es);
    word_t w;
    w.cmd = cmd; w.idx = idx; w.y0 = y0; w.y0_slope = y0s; w.dy = dy;
    w.half = half; w.y1_slope = y1s; w.frac = frac; w.typed = typed;
    w.exp_value = ev; w.exp_slope = es;
    directed_rows.push_back(w);
  endtask

  // Result side: compares each popped word with the oldest expectation.
  initial begin
    interp_t e;
    pop = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && pop && !empty) begin
        if (interp_expect_q.size() == 0) begin
          $display("%0t: unexpected word idx=%0d value=%h slope=%h", $time,
                   out_index_o, interp_value_o, interp_slope_o);
          error_count++;
        end else begin
          e = interp_expect_q.pop_front();
          if (out_index_o !== e.idx) begin
            $display("%0t: out_index expected %0d got %0d", $time, e.idx, out_index_o);
            error_count++;
          end
          if (interp_value_o !== e.value) begin
            $display("%0t: interp_value idx %0d expected %h got %h", $time, e.idx,
                     e.value, interp_value_o);
            error_count++;
          end
          if (interp_slope_o !== e.slope) begin
            $display("%0t: interp_slope idx %0d expected %h got %h", $time, e.idx,
                     e.slope, interp_slope_o);
            error_count++;
          end
        end
      end
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 300;
      end
      if (!rst_ni) begin
        pop <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else if (rx_gaps && $urandom_range(0, 3) == 0) begin
        stall_left = gap_len();
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin
    int          sent;
    word_t       w;
    logic [46:0] h_rand;
    rst_ni = 1'b0;
    push = 1'b0;
    cmd_i = CMD_LOAD;
    var_index_i = '0;
    start_value_i = '0;
    start_slope_i = '0;
    step_change_i = '0;
    half_change_i = '0;
    end_slope_i = '0;
    frac_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_STEP_SIZE;
    cfg_wdata_i = '0;
    step_h = 47'h1_0000_0000;
    step_hinv = 47'h1_0000_0000;
    foreach (loaded[i]) begin
      loaded[i] = 1'b0;
      formed[i] = 1'b0;
      y0_tab[i] = '0;
      slope_tab[i] = '0;
      dy_tab[i] = '0;
      c4_tab[i] = '0;
    end

    // At p = 0 the result is the start value and slope; at p = 1 it is the
    // end value and end slope, and a fraction above one counts as one.
    add_row(CMD_LOAD, 0, 48'sh5_8000_0000, -48'sh2_0000_0000, 48'sh3_0000_0000,
            '0, '0, '0, 0, '0, '0);
    add_row(CMD_FORM, 0, '0, '0, '0, 48'sh1_6666_6666, 48'sh0_B333_3333, '0, 0, '0, '0);
    add_row(CMD_INTERP, 0, '0, '0, '0, '0, 48'sh0_B333_3333, '0, 1,
            48'sh5_8000_0000, -48'sh2_0000_0000);
    add_row(CMD_INTERP, 0, '0, '0, '0, '0, 48'sh0_B333_3333, ONE_P, 1,
            48'sh8_8000_0000, 48'sh0_B333_3333);
    add_row(CMD_INTERP, 0, '0, '0, '0, '0, 48'sh0_B333_3333, 33'h1_FFFF_FFFF, 1,
            48'sh8_8000_0000, 48'sh0_B333_3333);
    add_row(CMD_INTERP, 0, '0, '0, '0, '0, 48'sh0_B333_3333, 33'h0_8000_0000, 0, '0, '0);
    add_row(CMD_LOAD, 63, Q48_MAX, Q48_MIN, Q48_MAX, '0, '0, '0, 0, '0, '0);
    add_row(CMD_FORM, 63, '0, '0, '0, Q48_MAX, Q48_MAX, '0, 0, '0, '0);
    add_row(CMD_INTERP, 63, '0, '0, '0, '0, Q48_MIN, ONE_P, 1, Q48_MAX, Q48_MIN);
    add_row(CMD_INTERP, 63, '0, '0, '0, '0, Q48_MIN, '0, 1, Q48_MAX, Q48_MIN);
    add_row(CMD_INTERP, 63, '0, '0, '0, '0, Q48_MAX, 33'h0_4000_0000, 0, '0, '0);
    add_row(CMD_IGNORED, 5, '1, '1, '1, '1, '1, '1, 0, '0, '0);
    add_row(CMD_LOAD, 42, Q48_MIN, Q48_MIN, Q48_MIN, '0, '0, '0, 0, '0, '0);
    add_row(CMD_FORM, 42, '0, '0, '0, Q48_MIN, Q48_MAX, '0, 0, '0, '0);
    add_row(CMD_INTERP, 42, '0, '0, '0, '0, Q48_MIN, 33'h0_8000_0000, 0, '0, '0);
    add_row(CMD_INTERP, 42, '0, '0, '0, '0, Q48_MAX, 33'h0_FFFF_FFFF, 0, '0, '0);
    add_row(CMD_LOAD, 21, '0, '0, '0, '0, '0, '0, 0, '0, '0);
    add_row(CMD_FORM, 21, '0, '0, '0, '0, '0, '0, 0, '0, '0);
    add_row(CMD_INTERP, 21, '0, '0, '0, '0, '0, 33'h0_0000_0001, 0, '0, '0);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) send_word(directed_rows[i], 1'b1);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        1: begin
          write_reg(REG_STEP_SIZE, 47'd1);
          write_reg(REG_STEP_RECIP, REG_MAX);
        end
        2: begin
          write_reg(REG_STEP_SIZE, REG_MAX);
          write_reg(REG_STEP_RECIP, 47'd1);
          hold_req = 1'b1;
        end
        3: begin
          h_rand = 47'($urandom_range(1, 255)) << $urandom_range(20, 36);
          write_reg(REG_STEP_SIZE, h_rand);
          write_reg(REG_STEP_RECIP, 47'((64'd1 << 64 - 1) / {17'd0, h_rand} * 2));
        end
        default: ;
      endcase
      rx_gaps = (phase != 1);
      sent = 0;
      while (sent < 100) begin
        w = rand_word();
        send_word(w, phase != 3);
        if (w.cmd != CMD_IGNORED) sent++;
      end
    end
    push <= 1'b0;

    while (interp_expect_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("tb_quartic_hermite_interpolator_unit: done, clean");
    end else begin
      $display("tb_quartic_hermite_interpolator_unit: done, errors");
    end
    $finish;
  end

endmodule

[quartic_hermite_interpolator_unit.f]
rtl/qhi_pkg.sv
rtl/qhi_fifo.sv
rtl/qhi_mul.sv
rtl/qhi_front.sv
rtl/qhi_back.sv
rtl/quartic_hermite_interpolator_unit.sv
rtl/qhi_checker.sv
tb/sv/tb_quartic_hermite_interpolator_unit.sv
